/* rtl/core/sigmoid_neuron_batch_trainer_top_assert.svh */
// Assertion macros for the neuron trainer checker
`ifndef SIGMOID_NEURON_BATCH_TRAINER_TOP_ASSERT_SVH
`define SIGMOID_NEURON_BATCH_TRAINER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SNB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define SNB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/snb_pkg.sv */
// Package: constants, types and sigmoid table for the neuron trainer
`timescale 1ns / 1ps
package snb_pkg;
    localparam int SigmoidEntries = 256;
    localparam int MaxBatch       = 256;
    localparam int AddrW          = 3;
    localparam logic [AddrW-1:0] RegRate  = 3'd0;
    localparam logic [AddrW-1:0] RegBatch = 3'd1;
    localparam logic [AddrW-1:0] RegInitW1 = 3'd2;
    localparam logic [AddrW-1:0] RegInitW2 = 3'd3;
    localparam logic [AddrW-1:0] RegInitB  = 3'd4;

    typedef struct packed {
        logic [8:0] sample_x1;
        logic [8:0] sample_x2;
        logic [8:0] sample_target;
        logic       restart;
    } sample_t;

    typedef struct packed {
        logic [15:0]        prediction;
        logic               batch_done;
        logic [15:0]        batch_cost;
        logic signed [23:0] weight_one;
        logic signed [23:0] weight_two;
        logic signed [23:0] offset_weight;
    } result_t;

    typedef struct packed {
        logic [15:0]        learning_rate;
        logic [8:0]         batch_size;
        logic signed [23:0] initial_weight_one;
        logic signed [23:0] initial_weight_two;
        logic signed [23:0] initial_offset;
    } cfg_t;

    // Long division of non-negative values, used only while building the table
    function automatic longint const_udiv(input longint num, input longint den);
        longint q, rem;
        q = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            q = q <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    // Table entry i: sigmoid of the bin center, fixed-point exp by series and squaring
    function automatic logic [15:0] sigmoid_entry(input int idx, input int entries);
        longint zc, u, v, v2, v3, v4, e, num, den, r;
        zc = const_udiv((2 * longint'(idx) + 1) <<< 19, longint'(entries)) - 524288;
        u  = (zc < 0) ? -zc : zc;
        v  = u <<< 6;
        v2 = (v * v) >>> 30;
        v3 = (v2 * v) >>> 30;
        v4 = (v2 * v2) >>> 30;
        e  = (longint'(1) <<< 30) - v + (v2 >>> 1) - const_udiv(v3, 6) + const_udiv(v4, 24);
        for (int k = 0; k < 8; k++)
        begin
            e = (e * e + (longint'(1) <<< 29)) >>> 30;
        end
        num = (zc >= 0) ? (longint'(1) <<< 30) : e;
        den = (longint'(1) <<< 30) + e;
        r = const_udiv((num <<< 16) + (den >>> 1), den);
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction
endpackage

/* rtl/core/snb_if.sv */
// Valid/ready channel interface
`timescale 1ns / 1ps
interface snb_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sigmoid_neuron_batch_trainer_top.sv */
// Top level: sigmoid neuron trainer with one shared multiplier and a divider
//
//  channel  | role   | payload
//  ---------+--------+----------------------------------------------------
//  smp      | sink   | sample_x1, sample_x2, sample_target, restart
//  res      | source | prediction, batch_done, batch_cost, three weights
//  apb      | slave  | five registers at byte address 4*i
//
// A sample passes through multiplier steps (products, table read, error and
// gradient terms) before its result is offered. A sample that closes a batch
// adds four passes of the 40-step divider and three update multiplies.
// Reset clears weights, sums and registers to their defaults. A stalled result
// holds the block in its output state; the next sample is taken once the result
// is consumed.
`timescale 1ns / 1ps
module sigmoid_neuron_batch_trainer_top #(
    parameter int SIGMOID_ENTRIES = snb_pkg::SigmoidEntries,
    parameter int MAX_BATCH       = snb_pkg::MaxBatch
) (
    input  logic                    clk,
    input  logic                    rst_n,
    snb_if.sink                     smp,
    snb_if.source                   res,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [snb_pkg::AddrW+1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import snb_pkg::*;

    localparam int IdxW = $clog2(SIGMOID_ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_Z, S_ROM, S_ERR, S_SQ, S_P, S_D, S_G1, S_G2, S_ACC,
        S_DIV, S_DWAIT, S_UPD, S_UWAIT, S_OUT
    } state_t;

    // sigmoid table, built at elaboration
    logic [15:0] rom [SIGMOID_ENTRIES];
    for (genvar g = 0; g < SIGMOID_ENTRIES; g++)
    begin : g_rom
        assign rom[g] = sigmoid_entry(g, SIGMOID_ENTRIES);
    end

    cfg_t cfg_reg;
    state_t state_reg;
    logic signed [23:0] w1_reg, w2_reg, b_reg;
    logic signed [39:0] g1_reg, g2_reg, gb_reg, sq_reg;
    logic [8:0]  seen_reg;
    sample_t     smp_reg;
    logic signed [39:0] acc_reg;
    logic [15:0] a_reg;
    logic signed [17:0] err_reg;
    logic signed [16:0] d_reg;
    logic [15:0] cost_reg;
    logic        done_reg;
    logic [1:0]  k_reg;
    logic        ovalid_reg;
    logic signed [39:0] q_reg [3];

    // shared multiplier operands
    logic signed [32:0] ma;
    logic signed [24:0] mb;
    logic signed [57:0] mp;
    snb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    logic        dstart, dbusy;
    logic signed [39:0] dnd, quo;
    logic [8:0]  n_eff;
    snb_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dnd),
                   .divisor(n_eff), .busy(dbusy), .quotient(quo));

    always_comb
    begin
        if (cfg_reg.batch_size == 9'd0)
            n_eff = 9'd1;
        else if (32'(cfg_reg.batch_size) > MAX_BATCH)
            n_eff = 9'(MAX_BATCH);
        else
            n_eff = cfg_reg.batch_size;
    end

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[AddrW+1:2])
            RegRate:   prdata = {16'd0, cfg_reg.learning_rate};
            RegBatch:  prdata = {23'd0, cfg_reg.batch_size};
            RegInitW1: prdata = 32'(cfg_reg.initial_weight_one);
            RegInitW2: prdata = 32'(cfg_reg.initial_weight_two);
            RegInitB:  prdata = 32'(cfg_reg.initial_offset);
            default:   prdata = 32'd0;
        endcase
    end

    // effective weights after optional restart
    logic signed [23:0] ew1, ew2;
    assign ew1 = smp_reg.restart ? cfg_reg.initial_weight_one : w1_reg;
    assign ew2 = smp_reg.restart ? cfg_reg.initial_weight_two : w2_reg;

    logic signed [39:0] sel_sum;
    always_comb
    begin
        unique case (k_reg)
            2'd0:    sel_sum = g1_reg;
            2'd1:    sel_sum = g2_reg;
            2'd2:    sel_sum = gb_reg;
            default: sel_sum = sq_reg;
        endcase
    end

    // operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_M1:
            begin
                ma = 33'(signed'({1'b0, smp_reg.sample_x1}));
                mb = 25'(ew1);
            end
            S_M2:
            begin
                ma = 33'(signed'({1'b0, smp_reg.sample_x2}));
                mb = 25'(ew2);
            end
            S_ERR:
            begin
                ma = 33'(err_reg);
                mb = 25'(err_reg);
            end
            S_SQ:
            begin
                ma = 33'({1'b0, a_reg});
                mb = 25'(17'h10000 - {1'b0, a_reg});
            end
            S_P:
            begin
                // err times p = floor(a(1-a)) from the product just finished
                ma = 33'(err_reg);
                mb = 25'(mp >>> 16);
            end
            S_D:
            begin
                // d taken straight from the product while it is registered
                ma = 33'(mp >>> 15);
                mb = 25'(signed'({1'b0, smp_reg.sample_x1}));
            end
            S_G1:
            begin
                ma = 33'(d_reg);
                mb = 25'(signed'({1'b0, smp_reg.sample_x2}));
            end
            S_UPD:
            begin
                ma = 33'(q_reg[k_reg]);
                mb = 25'(signed'({1'b0, cfg_reg.learning_rate}));
            end
            default: ;
        endcase
    end

    assign dstart = (state_reg == S_DIV);
    assign dnd    = sel_sum;

    logic signed [39:0] zc;
    logic [IdxW-1:0]    zi;
    logic signed [40:0] wn;
    logic signed [23:0] wsel;
    logic signed [23:0] wsat;
    always_comb
    begin
        if (acc_reg < -40'sd524288)
            zc = -40'sd524288;
        else if (acc_reg > 40'sd524287)
            zc = 40'sd524287;
        else
            zc = acc_reg;
        zi = IdxW'((41'(zc + 40'sd524288) * SIGMOID_ENTRIES) >>> 20);
        unique case (k_reg)
            2'd0:    wsel = w1_reg;
            2'd1:    wsel = w2_reg;
            default: wsel = b_reg;
        endcase
        wn = 41'(wsel) - 41'(mp >>> 24);
        if (wn > 41'sd8388607)
            wsat = 24'sh7FFFFF;
        else if (wn < -41'sd8388608)
            wsat = -24'sh800000;
        else
            wsat = wn[23:0];
    end

    logic [39:0] cq;
    assign cq = 40'(quo >>> 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cfg_reg    <= '{learning_rate: 16'd6554, batch_size: 9'd4, default: '0};
            w1_reg <= '0; w2_reg <= '0; b_reg <= '0;
            g1_reg <= '0; g2_reg <= '0; gb_reg <= '0; sq_reg <= '0;
            seen_reg   <= '0;
            ovalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            k_reg      <= '0;
            smp_reg    <= '0;
            acc_reg    <= '0;
            a_reg      <= '0;
            err_reg    <= '0;
            d_reg      <= '0;
            cost_reg   <= '0;
            q_reg      <= '{default: '0};
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[AddrW+1:2])
                    RegRate:   cfg_reg.learning_rate      <= pwdata[15:0];
                    RegBatch:  cfg_reg.batch_size         <= pwdata[8:0];
                    RegInitW1: cfg_reg.initial_weight_one <= pwdata[23:0];
                    RegInitW2: cfg_reg.initial_weight_two <= pwdata[23:0];
                    RegInitB:  cfg_reg.initial_offset     <= pwdata[23:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (smp.valid)
                    begin
                        smp_reg   <= smp.data;
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    // restart: reload weights and clear sums before this sample
                    if (smp_reg.restart)
                    begin
                        w1_reg <= cfg_reg.initial_weight_one;
                        w2_reg <= cfg_reg.initial_weight_two;
                        b_reg  <= cfg_reg.initial_offset;
                        g1_reg <= '0; g2_reg <= '0; gb_reg <= '0; sq_reg <= '0;
                        seen_reg <= '0;
                    end
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg <= 40'(mp);
                    state_reg <= S_Z;
                end
                S_Z:
                begin
                    acc_reg <= 40'((acc_reg + 40'(mp)) >>> 8) + 40'(b_reg);
                    state_reg <= S_ROM;
                end
                S_ROM:
                begin
                    a_reg   <= rom[zi];
                    err_reg <= 18'(signed'({2'b0, rom[zi]})) -
                               18'(signed'({1'b0, smp_reg.sample_target, 8'd0}));
                    state_reg <= S_ERR;
                end
                S_ERR: state_reg <= S_SQ;
                S_SQ:
                begin
                    sq_reg <= sq_reg + 40'(mp >>> 8);
                    state_reg <= S_P;
                end
                S_P: state_reg <= S_D;
                S_D:
                begin
                    // d = floor(2*err*p/65536) = floor(err*p/32768)
                    d_reg <= 17'(mp >>> 15);
                    state_reg <= S_G1;
                end
                S_G1:
                begin
                    g1_reg <= g1_reg + 40'(mp);
                    state_reg <= S_G2;
                end
                S_G2:
                begin
                    g2_reg <= g2_reg + 40'(mp);
                    gb_reg <= gb_reg + 40'(d_reg) * 40'sd256;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (seen_reg + 9'd1 >= n_eff)
                    begin
                        k_reg <= 2'd0; done_reg <= 1'b1; state_reg <= S_DIV;
                    end
                    else
                    begin
                        seen_reg <= seen_reg + 9'd1;
                        done_reg <= 1'b0; state_reg <= S_OUT; ovalid_reg <= 1'b1;
                    end
                end
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (!dbusy)
                    begin
                        if (k_reg == 2'd3)
                        begin
                            cost_reg <= (cq > 40'd65535) ? 16'hFFFF : cq[15:0];
                            k_reg <= 2'd0; state_reg <= S_UPD;
                        end
                        else
                        begin
                            q_reg[k_reg] <= quo;
                            k_reg <= k_reg + 2'd1; state_reg <= S_DIV;
                        end
                    end
                end
                S_UPD: state_reg <= S_UWAIT;
                S_UWAIT:
                begin
                    unique case (k_reg)
                        2'd0:    w1_reg <= wsat;
                        2'd1:    w2_reg <= wsat;
                        default: b_reg  <= wsat;
                    endcase
                    if (k_reg == 2'd2)
                    begin
                        g1_reg <= '0; g2_reg <= '0; gb_reg <= '0; sq_reg <= '0;
                        seen_reg <= '0; state_reg <= S_OUT; ovalid_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1; state_reg <= S_UPD;
                    end
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        ovalid_reg <= 1'b0; state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    result_t r;
    always_comb
    begin
        r.prediction    = a_reg;
        r.batch_done    = done_reg;
        r.batch_cost    = done_reg ? cost_reg : 16'd0;
        r.weight_one    = w1_reg;
        r.weight_two    = w2_reg;
        r.offset_weight = b_reg;
    end
    assign res.data  = r;
    assign res.valid = ovalid_reg;
    assign smp.ready = (state_reg == S_IDLE);
endmodule

/* rtl/core/snb_mul.sv */
// Shared signed multiplier with registered product
`timescale 1ns / 1ps
module snb_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [24:0] b,
    output logic signed [57:0] p
);
    logic signed [57:0] p_reg;
    always_ff @(posedge clk)
    begin
        p_reg <= 58'(a * b);
    end
    assign p = p_reg;
endmodule

/* rtl/core/snb_div.sv */
// Restoring divider: signed dividend by small positive divisor, truncating
`timescale 1ns / 1ps
module snb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [39:0] dividend,
    input  logic [8:0]         divisor,
    output logic               busy,
    output logic signed [39:0] quotient
);
    logic [39:0] mag_reg, mag_next;
    logic [9:0]  rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, busy_reg, busy_next;
    logic [8:0]  dv_reg, dv_next;
    logic [9:0]  trial;

    always_comb
    begin
        mag_next = mag_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        neg_next = neg_reg; busy_next = busy_reg; dv_next = dv_reg;
        trial = 10'd0;
        if (start)
        begin
            neg_next  = dividend[39];
            mag_next  = dividend[39] ? 40'(-dividend) : dividend;
            rem_next  = 10'd0;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[8:0], mag_reg[39]};
            mag_next = {mag_reg[38:0], 1'b0};
            if (trial >= {1'b0, dv_reg})
            begin
                rem_next = trial - {1'b0, dv_reg};
                mag_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        dv_reg  <= dv_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? 40'(-mag_reg) : mag_reg;
endmodule

/* rtl/core/snb_checker.sv */
// Port-level checker for the neuron trainer, bound to the top level
`timescale 1ns / 1ps
`include "sigmoid_neuron_batch_trainer_top_assert.svh"
module snb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_done,
    input logic [15:0] out_cost
);
    `SNB_ASSERT_IMP(a_no_ready_while_out, clk, rst_n, out_valid, !in_ready,
                    "ready while result pending")
    `SNB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                     "ready after accept")
    `SNB_ASSERT_IMP(a_cost_zero, clk, rst_n, out_valid && !out_done, out_cost == 16'd0,
                    "cost without batch end")
    `SNB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                     "result dropped")
endmodule

bind sigmoid_neuron_batch_trainer_top snb_checker u_snb_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(smp.valid), .in_ready(smp.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .out_done(res.data[88]), .out_cost(res.data[87:72])
);

/* dv/tb_top.sv */
// Testbench for the sigmoid neuron batch trainer: random samples checked against a local predictor
`timescale 1ns / 1ps
module tb_top;
    import snb_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int DRAIN_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW+1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    snb_if #(.W($bits(sample_t))) smp ();
    snb_if #(.W($bits(result_t))) res ();

    sigmoid_neuron_batch_trainer_top dut (
        .clk(clk), .rst_n(rst_n), .smp(smp.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor copy of the registers and the training state
    logic [15:0] rate_q;
    logic [8:0] batch_q;
    logic signed [23:0] init_w1_q, init_w2_q, init_b_q;
    longint w1_s, w2_s, b_s, gsum1_s, gsum2_s, gsumb_s, sqsum_s;
    int seen_s;
    logic [15:0] sigmoid_rom [SigmoidEntries];

    result_t result_queue [$];
    int mismatches = 0;
    int results_seen = 0;
    int batches_seen = 0;
    bit tx_quiet = 1'b0;  // stretch with no sender idling
    bit rx_quiet = 1'b0;  // stretch with no receiver idling
    bit rx_hold = 1'b0;   // long receiver hold-off

    function automatic longint floor_div256(longint v);
        return v >>> 8;
    endfunction

    function automatic longint clamp_weight(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Build the sigmoid table from the bin centers, exp by series and squaring
    function automatic logic [15:0] table_value(int idx);
        longint zc, u, v, v2, v3, v4, e, num, den, r;
        zc = (((2 * longint'(idx) + 1) <<< 19) / SigmoidEntries) - 524288;
        u = (zc < 0) ? -zc : zc;
        v = u <<< 6;
        v2 = (v * v) >>> 30;
        v3 = (v2 * v) >>> 30;
        v4 = (v2 * v2) >>> 30;
        e = (longint'(1) <<< 30) - v + v2 / 2 - v3 / 6 + v4 / 24;
        for (int k = 0; k < 8; k++)
        begin
            e = (e * e + (longint'(1) <<< 29)) >>> 30;
        end
        num = (zc >= 0) ? (longint'(1) <<< 30) : e;
        den = (longint'(1) <<< 30) + e;
        r = ((num <<< 16) + den / 2) / den;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic result_t train_on_sample(sample_t s);
        result_t r;
        longint x1, x2, t, z, idx, a, err, p, d, n, c, step;
        x1 = s.sample_x1;
        x2 = s.sample_x2;
        t = s.sample_target;
        if (s.restart)
        begin
            w1_s = init_w1_q;
            w2_s = init_w2_q;
            b_s = init_b_q;
            gsum1_s = 0; gsum2_s = 0; gsumb_s = 0; sqsum_s = 0; seen_s = 0;
        end
        z = floor_div256(x1 * w1_s + x2 * w2_s) + b_s;
        if (z < -524288) z = -524288;
        if (z > 524287) z = 524287;
        idx = ((z + 524288) * SigmoidEntries) >>> 20;
        if (idx > SigmoidEntries - 1) idx = SigmoidEntries - 1;
        a = sigmoid_rom[idx];
        err = a - (t <<< 8);
        p = (a * (65536 - a)) >>> 16;
        d = (2 * err * p) >>> 16;
        sqsum_s += (err * err) >>> 8;
        gsum1_s += d * x1;
        gsum2_s += d * x2;
        gsumb_s += d * 256;
        seen_s = (seen_s + 1) & 9'h1FF;
        n = batch_q;
        if (n < 1) n = 1;
        if (n > MaxBatch) n = MaxBatch;
        r = '0;
        r.prediction = a[15:0];
        if (seen_s >= n)
        begin
            c = (sqsum_s / n) >>> 8;
            r.batch_cost = (c > 65535) ? 16'hFFFF : c[15:0];
            step = (longint'(rate_q) * (gsum1_s / n)) >>> 24;
            w1_s = clamp_weight(w1_s - step);
            step = (longint'(rate_q) * (gsum2_s / n)) >>> 24;
            w2_s = clamp_weight(w2_s - step);
            step = (longint'(rate_q) * (gsumb_s / n)) >>> 24;
            b_s = clamp_weight(b_s - step);
            gsum1_s = 0; gsum2_s = 0; gsumb_s = 0; sqsum_s = 0; seen_s = 0;
            r.batch_done = 1'b1;
        end
        r.weight_one = w1_s[23:0];
        r.weight_two = w2_s[23:0];
        r.offset_weight = b_s[23:0];
        return r;
    endfunction

    // Two-phase register write; update the predictor copy on the access edge
    task automatic write_reg(logic [AddrW-1:0] idx, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegRate:   rate_q = value[15:0];
            RegBatch:  batch_q = value[8:0];
            RegInitW1: init_w1_q = value[23:0];
            RegInitW2: init_w2_q = value[23:0];
            RegInitB:  init_b_q = value[23:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] rate, logic [8:0] bsize,
                             logic [23:0] iw1, logic [23:0] iw2, logic [23:0] ib);
        write_reg(RegRate, {16'd0, rate});
        write_reg(RegBatch, {23'd0, bsize});
        write_reg(RegInitW1, {8'd0, iw1});
        write_reg(RegInitW2, {8'd0, iw2});
        write_reg(RegInitB, {8'd0, ib});
    endtask

    // Offer one item, idle at random unless a quiet stretch is on; predict on acceptance
    task automatic send_sample(sample_t s);
        while (!tx_quiet && $urandom_range(99) < 16)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid <= 1'b1;
        smp.data <= s;
        do @(posedge clk); while (!smp.ready);
        result_queue.push_back(train_on_sample(s));
        smp.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sample_t random_sample(int restart_pct);
        sample_t s;
        // mostly in-range values, a few over 1.0 so every bit toggles
        s.sample_x1 = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256));
        s.sample_x2 = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256));
        s.sample_target = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256));
        s.restart = ($urandom_range(99) < restart_pct);
        return s;
    endfunction

    // Wait for every expected item, then let the block settle before a register write
    task automatic drain;
        int guard;
        guard = 0;
        while (result_queue.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_defaults;
        sample_t s;
        s = '{sample_x1: 9'd256, sample_x2: 9'd0, sample_target: 9'd256, restart: 1'b0};
        send_sample(s);
        s = '{sample_x1: 9'd0, sample_x2: 9'd256, sample_target: 9'd0, restart: 1'b0};
        send_sample(s);
        s = '{sample_x1: 9'd511, sample_x2: 9'd511, sample_target: 9'd511, restart: 1'b0};
        send_sample(s);
        s = '{sample_x1: 9'd0, sample_x2: 9'd0, sample_target: 9'd0, restart: 1'b0};
        send_sample(s);
        drain();
    endtask

    task automatic test_extremes;
        sample_t s;
        // large positive weights saturate z high, then large negative ones clamp low
        configure(16'hFFFF, 9'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        s = '{sample_x1: 9'd256, sample_x2: 9'd256, sample_target: 9'd0, restart: 1'b1};
        send_sample(s);
        s.restart = 1'b0;
        send_sample(s);
        drain();
        configure(16'hFFFF, 9'd1, 24'h800000, 24'h800000, 24'h800000);
        s = '{sample_x1: 9'd511, sample_x2: 9'd511, sample_target: 9'd511, restart: 1'b1};
        send_sample(s);
        s.restart = 1'b0;
        send_sample(s);
        drain();
        // zero batch size acts as one; rate zero freezes weights
        configure(16'd0, 9'd0, 24'h010000, 24'hFF0000, 24'h000000);
        s = '{sample_x1: 9'd128, sample_x2: 9'd64, sample_target: 9'd200, restart: 1'b1};
        send_sample(s);
        send_sample(random_sample(0));
        drain();
        // batch above the maximum clamps to the maximum
        configure(16'd6554, 9'd511, 24'd0, 24'd0, 24'd0);
        s.restart = 1'b1;
        send_sample(s);
        drain();
    endtask

    task automatic test_batch_lowered;
        // start a long batch, then shrink it so the next sample closes it
        configure(16'd30000, 9'd8, 24'h020000, 24'hFE0000, 24'h008000);
        send_sample('{sample_x1: 9'd200, sample_x2: 9'd50, sample_target: 9'd256, restart: 1'b1});
        repeat (4) send_sample(random_sample(0));
        drain();
        write_reg(RegBatch, 32'd2);
        send_sample(random_sample(0));
        send_sample(random_sample(0));
        drain();
    endtask

    task automatic test_backpressure;
        // hold off the receiver for long while items keep coming
        configure(16'd6554, 9'd3, 24'd0, 24'd0, 24'd0);
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
            repeat (8) send_sample(random_sample(5));
        join
        drain();
    endtask

    task automatic test_random;
        int bs;
        for (int phase = 0; phase < 6; phase++)
        begin
            // small batches mostly, one phase at the largest size
            bs = (phase == 5) ? 256 : $urandom_range(1, 8);
            configure(16'($urandom), 9'(bs), 24'($signed($urandom_range(0, 8'hFF)) <<< 12),
                      24'($urandom), 24'($signed($urandom_range(0, 16'hFFFF)) - 32768));
            tx_quiet = (phase == 2);
            rx_quiet = (phase == 2);
            send_sample(random_sample(100));
            for (int i = 0; i < ((phase == 5) ? 260 : 80); i++)
                send_sample(random_sample(3));
            drain();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Receiver: random stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= !rx_hold && (rx_quiet || $urandom_range(99) >= 16);
    end

    // Compare each accepted item with the oldest prediction
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && res.valid && res.ready)
        begin
            got = res.data;
            results_seen++;
            if (got.batch_done) batches_seen++;
            if (result_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", got);
            end
            else
            begin
                want = result_queue.pop_front();
                if (got.prediction !== want.prediction || got.batch_done !== want.batch_done
                    || got.batch_cost !== want.batch_cost
                    || got.weight_one !== want.weight_one
                    || got.weight_two !== want.weight_two
                    || got.offset_weight !== want.offset_weight)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want a=%0d done=%0d cost=%0d w=%0d,%0d,%0d",
                                 want.prediction, want.batch_done, want.batch_cost,
                                 want.weight_one, want.weight_two, want.offset_weight);
                        $display("          got  a=%0d done=%0d cost=%0d w=%0d,%0d,%0d",
                                 got.prediction, got.batch_done, got.batch_cost,
                                 got.weight_one, got.weight_two, got.offset_weight);
                    end
                end
            end
        end
    end

    initial
    begin
        smp.valid = 1'b0;
        smp.data = '0;
        for (int i = 0; i < SigmoidEntries; i++)
            sigmoid_rom[i] = table_value(i);
        rate_q = 16'd6554; batch_q = 9'd4;
        init_w1_q = '0; init_w2_q = '0; init_b_q = '0;
        w1_s = 0; w2_s = 0; b_s = 0;
        gsum1_s = 0; gsum2_s = 0; gsumb_s = 0; sqsum_s = 0; seen_s = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_batch_lowered();
        test_backpressure();
        test_random();
        $display("covered %0d results, %0d batch updates, register extremes and a long stall",
                 results_seen, batches_seen);
        if (mismatches == 0 && result_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(20 * 900000);
        $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/snb_pkg.sv
rtl/core/snb_if.sv
rtl/core/snb_mul.sv
rtl/core/snb_div.sv
rtl/core/sigmoid_neuron_batch_trainer_top.sv
rtl/core/snb_checker.sv
dv/tb_top.sv
